/* src/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/tpq_pkg.sv */
// Package of the task priority queue: widths, codes, item and entry types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tpq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int TAG_BITS      = 16;
   localparam int FILL_BITS     = 5;

   typedef enum logic [1:0] {
      MODE_SUBMIT   = 2'd0,
      MODE_POP      = 2'd1,
      MODE_CANCEL   = 2'd2,
      MODE_SHUTDOWN = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_CLOSED    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_PLACE,
      ST_POP_HEAD,
      ST_FIND,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      mode_type                 mode;
      logic [PRIORITY_BITS-1:0] priority_req;
      logic [TAG_BITS-1:0]      tag;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [TAG_BITS-1:0]      out_tag;
      logic [PRIORITY_BITS-1:0] out_priority;
      logic [FILL_BITS-1:0]     fill_count;
   } rsp_type;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [TAG_BITS-1:0]      tag;
   } entry_type;

endpackage

/* src/tpq_store.sv */
// Entry memory of the task priority queue: one write port, one registered read port.
// Depends on tpq_pkg for the entry type.
`timescale 1ns / 1ps

module tpq_store #(
   parameter int DEPTH = tpq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output tpq_pkg::entry_type       rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  tpq_pkg::entry_type       wr_data
);

   tpq_pkg::entry_type mem_ff [DEPTH];
   tpq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/task_priority_queue_top.sv */
// Task priority queue top level: sequencer, counters and result register.
// Depends on tpq_pkg and tpq_store.
`timescale 1ns / 1ps

// A bounded queue of tagged tasks kept sorted from highest to lowest priority, with
// equal priorities served oldest first. An item is taken when start is high and busy
// is low; each item gives exactly one result, shown on rsp_item for one cycle while
// rsp_valid is high, and the receiver cannot hold it off. The entries live in one
// memory with one write and one registered read per cycle, and a small sequencer
// walks it one entry a cycle. A shutdown, a rejected submit or cancel, a pop on an
// empty queue and a submit into an empty queue are answered from idle, the result
// in the cycle after they are taken. A submit into a non-empty queue moves each entry
// of lower priority down one place from the tail, then writes the new one. A pop takes
// the head, a cancel the first entry with its tag; each later one moves up one place.
module task_priority_queue_top #(
   parameter int DEPTH = tpq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tpq_pkg::req_type req_item,
   output logic             rsp_valid,
   output tpq_pkg::rsp_type rsp_item
);

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   tpq_pkg::state_type  state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] held_ff, held_in;
   logic                closed_ff, closed_in;
   tpq_pkg::req_type    op_ff, op_in;
   tpq_pkg::entry_type  pop_ff, pop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tpq_pkg::rsp_type    rsp_item_ff, rsp_item_in;

   logic [IDX_BITS-1:0] rd_addr;
   tpq_pkg::entry_type  rd_data;
   logic                wr_en;
   logic [IDX_BITS-1:0] wr_addr;
   tpq_pkg::entry_type  wr_data;

   logic                finish;
   tpq_pkg::status_type fin_status;
   logic [CNT_BITS-1:0] fin_held;
   tpq_pkg::entry_type  fin_entry;
   tpq_pkg::entry_type  new_entry;
   logic [CNT_BITS-1:0] idx_plus;
   logic                has_next;
   logic                has_next2;

   tpq_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   assign idx_plus  = CNT_BITS'(idx_ff) + CNT_BITS'(1);
   assign has_next  = idx_plus < held_ff;
   assign has_next2 = ({1'b0, idx_plus} + (CNT_BITS + 1)'(1)) < {1'b0, held_ff};
   assign new_entry = '{prio: op_ff.priority_req, tag: op_ff.tag};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpq_pkg::ST_IDLE;
         idx_ff       <= '0;
         held_ff      <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         held_ff      <= held_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pop_ff      <= pop_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      closed_in    = closed_ff;
      op_in        = op_ff;
      pop_in       = pop_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      finish       = 1'b0;
      fin_status   = tpq_pkg::STATUS_OK;
      fin_held     = held_ff;
      fin_entry    = '0;

      unique case (state_ff)
         tpq_pkg::ST_IDLE: begin
            if (start) begin
               op_in  = req_item;
               pop_in = '0;
               unique case (req_item.mode)
                  tpq_pkg::MODE_SUBMIT: begin
                     if (closed_ff) begin
                        finish     = 1'b1;
                        fin_status = tpq_pkg::STATUS_CLOSED;
                     end else if (held_ff >= CNT_BITS'(DEPTH)) begin
                        finish     = 1'b1;
                        fin_status = tpq_pkg::STATUS_FULL;
                     end else if (held_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = '{prio: req_item.priority_req, tag: req_item.tag};
                        finish   = 1'b1;
                        fin_held = held_ff + CNT_BITS'(1);
                     end else begin
                        rd_addr  = IDX_BITS'(held_ff - CNT_BITS'(1));
                        idx_in   = IDX_BITS'(held_ff - CNT_BITS'(1));
                        state_in = tpq_pkg::ST_INSERT;
                     end
                  end
                  tpq_pkg::MODE_POP: begin
                     if (held_ff == '0) begin
                        finish     = 1'b1;
                        fin_status = tpq_pkg::STATUS_EMPTY;
                     end else begin
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = tpq_pkg::ST_POP_HEAD;
                     end
                  end
                  tpq_pkg::MODE_CANCEL: begin
                     if (closed_ff) begin
                        finish     = 1'b1;
                        fin_status = tpq_pkg::STATUS_CLOSED;
                     end else if (held_ff == '0) begin
                        finish     = 1'b1;
                        fin_status = tpq_pkg::STATUS_NOT_FOUND;
                     end else begin
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = tpq_pkg::ST_FIND;
                     end
                  end
                  tpq_pkg::MODE_SHUTDOWN: begin
                     closed_in = 1'b1;
                     finish    = 1'b1;
                     fin_held  = '0;
                  end
                  default: begin
                     finish = 1'b0;
                  end
               endcase
            end
         end
         tpq_pkg::ST_INSERT: begin
            wr_en = 1'b1;
            if (rd_data.prio < op_ff.priority_req) begin
               wr_addr = IDX_BITS'(idx_plus);
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = tpq_pkg::ST_PLACE;
               end else begin
                  rd_addr = idx_ff - IDX_BITS'(1);
                  idx_in  = idx_ff - IDX_BITS'(1);
               end
            end else begin
               wr_addr  = IDX_BITS'(idx_plus);
               wr_data  = new_entry;
               finish   = 1'b1;
               fin_held = held_ff + CNT_BITS'(1);
            end
         end
         tpq_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = new_entry;
            finish   = 1'b1;
            fin_held = held_ff + CNT_BITS'(1);
         end
         tpq_pkg::ST_POP_HEAD: begin
            pop_in = rd_data;
            if (has_next) begin
               rd_addr  = IDX_BITS'(idx_plus);
               state_in = tpq_pkg::ST_SHIFT;
            end else begin
               finish    = 1'b1;
               fin_held  = held_ff - CNT_BITS'(1);
               fin_entry = rd_data;
            end
         end
         tpq_pkg::ST_FIND: begin
            if (rd_data.tag == op_ff.tag) begin
               if (has_next) begin
                  rd_addr  = IDX_BITS'(idx_plus);
                  state_in = tpq_pkg::ST_SHIFT;
               end else begin
                  finish   = 1'b1;
                  fin_held = held_ff - CNT_BITS'(1);
               end
            end else if (has_next) begin
               rd_addr = IDX_BITS'(idx_plus);
               idx_in  = IDX_BITS'(idx_plus);
            end else begin
               finish     = 1'b1;
               fin_status = tpq_pkg::STATUS_NOT_FOUND;
            end
         end
         tpq_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            if (has_next2) begin
               rd_addr = IDX_BITS'(idx_plus + CNT_BITS'(1));
               idx_in  = IDX_BITS'(idx_plus);
            end else begin
               finish   = 1'b1;
               fin_held = held_ff - CNT_BITS'(1);
               if (op_ff.mode == tpq_pkg::MODE_POP) begin
                  fin_entry = pop_ff;
               end
            end
         end
         default: begin
            state_in = tpq_pkg::ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in                 = tpq_pkg::ST_IDLE;
         held_in                  = fin_held;
         rsp_valid_in             = 1'b1;
         rsp_item_in.status       = fin_status;
         rsp_item_in.out_tag      = fin_entry.tag;
         rsp_item_in.out_priority = fin_entry.prio;
         rsp_item_in.fill_count   = tpq_pkg::FILL_BITS'(fin_held);
      end
   end

   assign busy      = state_ff != tpq_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

/* src/tpq_checker.sv */
// Port-level checker of the task priority queue, bound to the top level.
// Depends on tpq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tpq_pkg::req_type req_item,
   input logic             rsp_valid,
   input tpq_pkg::rsp_type rsp_item
);

   logic accept;
   logic shutdown_accept;
   logic shutdown_done;
   logic rsp_failed;
   logic no_payload;
   logic rsp_closed;

   assign accept          = start && !busy;
   assign shutdown_accept = accept && req_item.mode == tpq_pkg::MODE_SHUTDOWN;
   assign shutdown_done   = rsp_valid && rsp_item.status == tpq_pkg::STATUS_OK &&
                            rsp_item.fill_count == '0;
   assign rsp_failed      = rsp_valid && rsp_item.status != tpq_pkg::STATUS_OK;
   assign no_payload      = rsp_item.out_tag == '0 && rsp_item.out_priority == '0;
   assign rsp_closed      = rsp_valid && rsp_item.status == tpq_pkg::STATUS_CLOSED;

   `ASSERT_NEXT(a_accept_progress, clock, reset, accept, rsp_valid || busy)
   `ASSERT_NEXT(a_shutdown_result, clock, reset, shutdown_accept, shutdown_done)
   `ASSERT_IMPLY(a_fail_no_payload, clock, reset, rsp_failed, no_payload)
   `ASSERT_IMPLY(a_closed_is_empty, clock, reset, rsp_closed, rsp_item.fill_count == '0)

endmodule

bind task_priority_queue_top tpq_checker u_tpq_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_item (req_item),
   .rsp_valid(rsp_valid),
   .rsp_item (rsp_item)
);

/* verif/task_priority_queue_top_tb.sv */
// Testbench of the task priority queue: directed table, three random phases, rest of table.
// Results are checked field by field against a listed table result or a queue predictor
// kept in step with the items accepted. Depends on tpq_pkg and task_priority_queue_top.
`timescale 1ns / 1ps

module task_priority_queue_top_tb;

   localparam int DEPTH       = tpq_pkg::DEPTH_DEFAULT;
   localparam int HALF_PERIOD = 2;
   localparam int QUIET_LIMIT = 4000;
   localparam int OPEN_ROWS   = 12;
   localparam int ALL_ROWS    = 17;
   localparam int PHASE_ITEMS = 250;

   typedef struct packed {
      tpq_pkg::mode_type                 mode;
      logic [tpq_pkg::PRIORITY_BITS-1:0] prio;
      logic [tpq_pkg::TAG_BITS-1:0]      tag;
      logic [4:0]                        reps;
      logic                              listed;
      tpq_pkg::rsp_type                  result;
   } step_row_type;

   localparam tpq_pkg::rsp_type UNLISTED = '{tpq_pkg::STATUS_OK, 16'h0000, 8'h00, 5'd0};

   // Submit rows with several repeats use consecutive tags.
   localparam step_row_type STEPS [ALL_ROWS] = '{
      '{tpq_pkg::MODE_POP,      8'h00, 16'h0000, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_EMPTY,     16'h0000, 8'h00, 5'd0}},
      '{tpq_pkg::MODE_CANCEL,   8'h00, 16'h0005, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_NOT_FOUND, 16'h0000, 8'h00, 5'd0}},
      '{tpq_pkg::MODE_SUBMIT,   8'h00, 16'h0000, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_OK,        16'h0000, 8'h00, 5'd1}},
      '{tpq_pkg::MODE_SUBMIT,   8'hff, 16'hffff, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_OK,        16'h0000, 8'h00, 5'd2}},
      '{tpq_pkg::MODE_SUBMIT,   8'h80, 16'h1234, 5'd1,  1'b0, UNLISTED},
      '{tpq_pkg::MODE_SUBMIT,   8'h80, 16'h1234, 5'd1,  1'b0, UNLISTED},
      '{tpq_pkg::MODE_CANCEL,   8'h00, 16'h1234, 5'd1,  1'b0, UNLISTED},
      '{tpq_pkg::MODE_POP,      8'h00, 16'h0000, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_OK,        16'hffff, 8'hff, 5'd2}},
      '{tpq_pkg::MODE_SUBMIT,   8'h80, 16'haaa0, 5'd14, 1'b0, UNLISTED},
      '{tpq_pkg::MODE_SUBMIT,   8'h07, 16'h0007, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_FULL,      16'h0000, 8'h00, 5'd16}},
      '{tpq_pkg::MODE_CANCEL,   8'h00, 16'h9999, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_NOT_FOUND, 16'h0000, 8'h00, 5'd16}},
      '{tpq_pkg::MODE_POP,      8'h00, 16'h0000, 5'd1,  1'b0, UNLISTED},
      '{tpq_pkg::MODE_SHUTDOWN, 8'h00, 16'h0000, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_OK,        16'h0000, 8'h00, 5'd0}},
      '{tpq_pkg::MODE_SUBMIT,   8'hff, 16'hffff, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_CLOSED,    16'h0000, 8'h00, 5'd0}},
      '{tpq_pkg::MODE_CANCEL,   8'h00, 16'hffff, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_CLOSED,    16'h0000, 8'h00, 5'd0}},
      '{tpq_pkg::MODE_POP,      8'h00, 16'h0000, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_EMPTY,     16'h0000, 8'h00, 5'd0}},
      '{tpq_pkg::MODE_SHUTDOWN, 8'hff, 16'hffff, 5'd1,  1'b1,
        '{tpq_pkg::STATUS_OK,        16'h0000, 8'h00, 5'd0}}
   };

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic             rsp_valid;
   tpq_pkg::req_type req_item;
   tpq_pkg::rsp_type rsp_item;

   tpq_pkg::entry_type shadow_entries[$];
   logic               shadow_closed;
   tpq_pkg::rsp_type   pending_results[$];
   tpq_pkg::rsp_type   oldest;
   int                 items_sent;
   int                 fail_count;
   int                 quiet_cycles;

   task_priority_queue_top #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic tpq_pkg::rsp_type predict_queue_op(input tpq_pkg::req_type item);
      tpq_pkg::rsp_type   res;
      tpq_pkg::entry_type fresh;
      int                 pos;
      logic               found;
      res = UNLISTED;
      found = 1'b0;
      case (item.mode)
         tpq_pkg::MODE_SUBMIT: begin
            if (shadow_closed) begin
               res.status = tpq_pkg::STATUS_CLOSED;
            end else if (shadow_entries.size() >= DEPTH) begin
               res.status = tpq_pkg::STATUS_FULL;
            end else begin
               // Equal priorities stay in arrival order.
               pos = 0;
               while (pos < shadow_entries.size() &&
                      shadow_entries[pos].prio >= item.priority_req) begin
                  pos++;
               end
               fresh.prio = item.priority_req;
               fresh.tag = item.tag;
               shadow_entries.insert(pos, fresh);
            end
         end
         tpq_pkg::MODE_POP: begin
            if (shadow_entries.size() == 0) begin
               res.status = tpq_pkg::STATUS_EMPTY;
            end else begin
               res.out_tag = shadow_entries[0].tag;
               res.out_priority = shadow_entries[0].prio;
               shadow_entries.delete(0);
            end
         end
         tpq_pkg::MODE_CANCEL: begin
            if (shadow_closed) begin
               res.status = tpq_pkg::STATUS_CLOSED;
            end else begin
               pos = 0;
               while (!found && pos < shadow_entries.size()) begin
                  if (shadow_entries[pos].tag == item.tag) begin
                     shadow_entries.delete(pos);
                     found = 1'b1;
                  end
                  pos++;
               end
               res.status = found ? tpq_pkg::STATUS_OK : tpq_pkg::STATUS_NOT_FOUND;
            end
         end
         default: begin
            shadow_entries.delete();
            shadow_closed = 1'b1;
         end
      endcase
      res.fill_count = tpq_pkg::FILL_BITS'(shadow_entries.size());
      return res;
   endfunction

   function automatic logic [tpq_pkg::TAG_BITS-1:0] pick_tag();
      if ($urandom_range(1) == 0) begin
         return tpq_pkg::TAG_BITS'($urandom_range(7));
      end
      return tpq_pkg::TAG_BITS'($urandom);
   endfunction

   function automatic logic [tpq_pkg::PRIORITY_BITS-1:0] pick_priority();
      case ($urandom_range(3))
         0: return tpq_pkg::PRIORITY_BITS'($urandom_range(3));
         1: return tpq_pkg::PRIORITY_BITS'(255 - $urandom_range(3));
         default: return tpq_pkg::PRIORITY_BITS'($urandom);
      endcase
   endfunction

   function automatic tpq_pkg::req_type make_item(input tpq_pkg::mode_type mode);
      tpq_pkg::req_type item;
      item.mode = mode;
      item.priority_req = pick_priority();
      item.tag = pick_tag();
      // Most cancels name a tag that is held, so that they hit.
      if (mode == tpq_pkg::MODE_CANCEL && shadow_entries.size() != 0 &&
          $urandom_range(9) < 7) begin
         item.tag = shadow_entries[$urandom_range(shadow_entries.size() - 1)].tag;
      end
      return item;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] exp_value,
                                       input logic [31:0] act_value);
      if (exp_value !== act_value) begin
         $error("%s mismatch: expected %0h, actual %0h", field, exp_value, act_value);
         fail_count++;
      end
   endfunction

   task automatic issue(input tpq_pkg::req_type item, input int idle_pct,
                        input logic listed, input tpq_pkg::rsp_type listed_result);
      tpq_pkg::rsp_type predicted;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_item <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_queue_op(item);
      pending_results.push_back(listed ? listed_result : predicted);
      items_sent++;
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic walk_steps(input int first, input int last, input int idle_pct);
      tpq_pkg::req_type item;
      int               row;
      int               k;
      for (row = first; row < last; row++) begin
         for (k = 0; k < STEPS[row].reps; k++) begin
            item.mode = STEPS[row].mode;
            item.priority_req = STEPS[row].prio;
            item.tag = STEPS[row].tag + tpq_pkg::TAG_BITS'(k);
            issue(item, idle_pct, STEPS[row].listed, STEPS[row].result);
         end
      end
   endtask

   task automatic run_random(input int count, input int idle_pct);
      int stop_at;
      int burst;
      int k;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            burst = $urandom_range(20, 12);
            for (k = 0; k < burst; k++) begin
               issue(make_item(tpq_pkg::MODE_SUBMIT), idle_pct, 1'b0, UNLISTED);
            end
         end else if (pick == 1) begin
            burst = $urandom_range(18, 10);
            for (k = 0; k < burst; k++) begin
               issue(make_item(tpq_pkg::MODE_POP), idle_pct, 1'b0, UNLISTED);
            end
         end else begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               issue(make_item(tpq_pkg::MODE_SUBMIT), idle_pct, 1'b0, UNLISTED);
            end else if (pick < 75) begin
               issue(make_item(tpq_pkg::MODE_POP), idle_pct, 1'b0, UNLISTED);
            end else begin
               issue(make_item(tpq_pkg::MODE_CANCEL), idle_pct, 1'b0, UNLISTED);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding: status %0d, fill %0d",
                   rsp_item.status, rsp_item.fill_count);
            fail_count++;
         end else begin
            oldest = pending_results.pop_front();
            check_field("status", 32'(oldest.status), 32'(rsp_item.status));
            check_field("out_tag", 32'(oldest.out_tag), 32'(rsp_item.out_tag));
            check_field("out_priority", 32'(oldest.out_priority),
                        32'(rsp_item.out_priority));
            check_field("fill_count", 32'(oldest.fill_count), 32'(rsp_item.fill_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      shadow_closed = 1'b0;
      items_sent = 0;
      fail_count = 0;
      quiet_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      walk_steps(0, OPEN_ROWS, 15);
      wait_all_results();
      run_random(PHASE_ITEMS, 15);
      wait_all_results();
      run_random(PHASE_ITEMS, 64);
      wait_all_results();
      run_random(PHASE_ITEMS, 0);
      // Shutdown closes the queue for good, so it comes last.
      walk_steps(OPEN_ROWS, ALL_ROWS, 0);
      wait_all_results();
      repeat (DEPTH + 8) @(posedge clock);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* task_priority_queue_top.f */
+incdir+src
src/tpq_pkg.sv
src/tpq_store.sv
src/task_priority_queue_top.sv
src/tpq_checker.sv
verif/task_priority_queue_top_tb.sv
